@@ rtl/core/sfn_pkg.sv @@
`timescale 1ns / 1ps

package sfn_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int FREQ_W    = 24;
	localparam int OUT_W     = 20;

	// lattice cell index and corner coordinate widths
	localparam int CELL_W    = 18;
	localparam int CORNER_W  = CELL_W + 1;
	localparam int KERN_W    = 16;

	localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(1 << FRAC_BITS);

	// (sqrt3-1)/2 and (3-sqrt3)/6 rounded to 16 fraction bits
	localparam logic signed [15:0] SKEW_FX   = 16'sd23988;
	localparam logic signed [15:0] UNSKEW_FX = 16'sd13849;

	localparam logic signed [OUT_W+1:0] OUT_MAX = 22'sd524287;
	localparam logic signed [OUT_W+1:0] OUT_MIN = -22'sd524288;

	typedef struct packed {
		logic ox;
		logic oz;
	} corner_ofs_t;

endpackage

@@ rtl/core/sfn_corner.sv @@
`timescale 1ns / 1ps

// falloff kernel of one simplex corner, six register stages
module sfn_corner
	import sfn_pkg::*;
(
	input  logic                       clk,
	input  logic signed [COORD_W-1:0]  px,
	input  logic signed [COORD_W-1:0]  pz,
	input  logic signed [CELL_W-1:0]   ix,
	input  logic signed [CELL_W-1:0]   iz,
	input  corner_ofs_t                ofs,
	output logic        [KERN_W-1:0]   kern
);

	localparam int PROD_W = CORNER_W + 1 + 16;
	localparam int D_W    = 37;

	logic signed [CORNER_W-1:0] cx, cz;
	logic signed [CORNER_W:0]   csum;

	logic signed [PROD_W-1:0]   uprod_s5;
	logic signed [CORNER_W-1:0] cx_s5, cz_s5;
	logic signed [COORD_W-1:0]  px_s5, pz_s5;

	logic signed [PROD_W-17:0]  unskew;
	logic signed [D_W-1:0]      dx_w, dz_w;
	logic                       near;
	logic signed [16:0]         dx_s6, dz_s6;
	logic                       near_s6;

	logic signed [33:0]         dx2, dz2;
	logic        [31:0]         dx2_s7, dz2_s7;
	logic                       near_s7;

	logic signed [34:0]         t_w;
	logic        [15:0]         f_s8;

	logic        [31:0]         ff;
	logic        [15:0]         f_s9;
	logic        [15:0]         f2_s9;

	logic        [31:0]         fff;

	always_comb begin
		cx   = CORNER_W'(ix) + CORNER_W'(ofs.ox);
		cz   = CORNER_W'(iz) + CORNER_W'(ofs.oz);
		csum = (CORNER_W+1)'(cx) + (CORNER_W+1)'(cz);
	end

	always_ff @(posedge clk) begin
		uprod_s5 <= PROD_W'(csum) * PROD_W'(UNSKEW_FX);
		cx_s5    <= cx;
		cz_s5    <= cz;
		px_s5    <= px;
		pz_s5    <= pz;
	end

	// unskew product is floored by dropping its 16 fraction bits
	always_comb begin
		unskew = uprod_s5[PROD_W-1:16];
		dx_w   = D_W'(px_s5) - (D_W'(cx_s5) <<< FRAC_BITS) + D_W'(unskew);
		dz_w   = D_W'(pz_s5) - (D_W'(cz_s5) <<< FRAC_BITS) + D_W'(unskew);
		near   = (dx_w < D_W'(65536)) && (dx_w > -D_W'(65536))
			&& (dz_w < D_W'(65536)) && (dz_w > -D_W'(65536));
	end

	always_ff @(posedge clk) begin
		dx_s6   <= dx_w[16:0];
		dz_s6   <= dz_w[16:0];
		near_s6 <= near;
	end

	always_comb begin
		dx2 = 34'(dx_s6) * 34'(dx_s6);
		dz2 = 34'(dz_s6) * 34'(dz_s6);
	end

	always_ff @(posedge clk) begin
		dx2_s7  <= dx2[31:0];
		dz2_s7  <= dz2[31:0];
		near_s7 <= near_s6;
	end

	always_comb begin
		t_w = 35'sd2147483648 - $signed({3'b000, dx2_s7}) - $signed({3'b000, dz2_s7});
	end

	// t is at most 0.5 here, so f fits in 16 bits
	always_ff @(posedge clk) begin
		if (near_s7 && t_w > 35'sd0)
			f_s8 <= t_w[31:16];
		else
			f_s8 <= '0;
	end

	assign ff = 32'(f_s8) * 32'(f_s8);

	always_ff @(posedge clk) begin
		f_s9  <= f_s8;
		f2_s9 <= ff[31:16];
	end

	assign fff = 32'(f2_s9) * 32'(f_s9);

	always_ff @(posedge clk) begin
		kern <= fff[31:16];
	end

endmodule

@@ rtl/core/simplex_falloff_noise_2d.sv @@
`timescale 1ns / 1ps

// Gradient-free 2D simplex falloff noise, one point per clock cycle. A word is
// taken whenever start is high; busy never rises, since the pipeline always
// advances. Each result appears on noise_value with done high for exactly one
// cycle, in the order the points came in; the receiver must take it then,
// there is no way to hold it. The pipeline has eleven stages: scale multiply,
// saturate, skew multiply, cell floor, then three parallel six-stage corner
// units (unskew, distance, square, falloff, falloff squared, cube) and the
// final sum. Write cfg_wdata with cfg_wen only while no word is in flight.
module simplex_falloff_noise_2d
	import sfn_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_z,
	input  logic                      cfg_wen,
	input  logic        [FREQ_W-1:0]  cfg_wdata,
	output logic                      done,
	output logic signed [OUT_W-1:0]   noise_value
);

	localparam int STAGES = 11;
	localparam int MUL_W  = COORD_W + FREQ_W;
	localparam int SK_W   = COORD_W + 1 + 16;

	logic [FREQ_W-1:0] freq_q;
	logic [STAGES-1:0] valid_q;

	logic signed [MUL_W-1:0]   mx_s1, mz_s1;

	logic signed [MUL_W-17:0]  shx, shz;
	logic signed [COORD_W-1:0] satx, satz;
	logic signed [COORD_W-1:0] px_s2, pz_s2;
	logic signed [COORD_W:0]   psum_s2;

	logic signed [SK_W-1:0]    skprod_s3;
	logic signed [COORD_W-1:0] px_s3, pz_s3;

	logic signed [SK_W-17:0]   skew;
	logic signed [COORD_W+1:0] sx, sz;
	logic signed [COORD_W-1:0] px_s4, pz_s4;
	logic signed [CELL_W-1:0]  ix_s4, iz_s4;
	logic                      xmajor_s4;

	logic [KERN_W-1:0] k_org, k_far, k_mid;
	corner_ofs_t       mid_ofs;

	logic        [KERN_W+1:0] ksum;
	logic signed [OUT_W+1:0]  r_w;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q  <= FREQ_RESET;
			valid_q <= '0;
		end else begin
			if (cfg_wen)
				freq_q <= cfg_wdata;
			valid_q <= {valid_q[STAGES-2:0], start};
		end
	end

	assign done = valid_q[STAGES-1];

	// stage 1: scale by frequency
	always_ff @(posedge clk) begin
		mx_s1 <= MUL_W'(point_x) * $signed({{(MUL_W-FREQ_W){1'b0}}, freq_q});
		mz_s1 <= MUL_W'(point_z) * $signed({{(MUL_W-FREQ_W){1'b0}}, freq_q});
	end

	// stage 2: floor to 16 fraction bits and saturate
	always_comb begin
		shx = mx_s1[MUL_W-1:FRAC_BITS];
		shz = mz_s1[MUL_W-1:FRAC_BITS];
		if (shx > (MUL_W-16)'(32'sh7fffffff))
			satx = 32'sh7fffffff;
		else if (shx < (MUL_W-16)'(-33'sh80000000))
			satx = 32'sh80000000;
		else
			satx = shx[COORD_W-1:0];
		if (shz > (MUL_W-16)'(32'sh7fffffff))
			satz = 32'sh7fffffff;
		else if (shz < (MUL_W-16)'(-33'sh80000000))
			satz = 32'sh80000000;
		else
			satz = shz[COORD_W-1:0];
	end

	always_ff @(posedge clk) begin
		px_s2   <= satx;
		pz_s2   <= satz;
		psum_s2 <= (COORD_W+1)'(satx) + (COORD_W+1)'(satz);
	end

	// stage 3: skew product
	always_ff @(posedge clk) begin
		skprod_s3 <= SK_W'(psum_s2) * SK_W'(SKEW_FX);
		px_s3     <= px_s2;
		pz_s3     <= pz_s2;
	end

	// stage 4: skewed point, cell floor, middle corner choice
	always_comb begin
		skew = skprod_s3[SK_W-1:FRAC_BITS];
		sx   = (COORD_W+2)'(px_s3) + (COORD_W+2)'(skew);
		sz   = (COORD_W+2)'(pz_s3) + (COORD_W+2)'(skew);
	end

	always_ff @(posedge clk) begin
		px_s4     <= px_s3;
		pz_s4     <= pz_s3;
		ix_s4     <= sx[COORD_W+1:FRAC_BITS];
		iz_s4     <= sz[COORD_W+1:FRAC_BITS];
		xmajor_s4 <= sx[FRAC_BITS-1:0] >= sz[FRAC_BITS-1:0];
	end

	assign mid_ofs = xmajor_s4 ? corner_ofs_t'{ox: 1'b1, oz: 1'b0}
		: corner_ofs_t'{ox: 1'b0, oz: 1'b1};

	// stages 5 to 10: one kernel unit per corner
	sfn_corner u_org (
		.clk  (clk),
		.px   (px_s4),
		.pz   (pz_s4),
		.ix   (ix_s4),
		.iz   (iz_s4),
		.ofs  (corner_ofs_t'{ox: 1'b0, oz: 1'b0}),
		.kern (k_org)
	);

	sfn_corner u_far (
		.clk  (clk),
		.px   (px_s4),
		.pz   (pz_s4),
		.ix   (ix_s4),
		.iz   (iz_s4),
		.ofs  (corner_ofs_t'{ox: 1'b1, oz: 1'b1}),
		.kern (k_far)
	);

	sfn_corner u_mid (
		.clk  (clk),
		.px   (px_s4),
		.pz   (pz_s4),
		.ix   (ix_s4),
		.iz   (iz_s4),
		.ofs  (mid_ofs),
		.kern (k_mid)
	);

	// stage 11: 16 * sum - 1, saturated
	always_comb begin
		ksum = (KERN_W+2)'(k_org) + (KERN_W+2)'(k_far) + (KERN_W+2)'(k_mid);
		r_w  = $signed({ksum, 4'b0000}) - 22'sd65536;
	end

	always_ff @(posedge clk) begin
		if (r_w > OUT_MAX)
			noise_value <= OUT_MAX[OUT_W-1:0];
		else if (r_w < OUT_MIN)
			noise_value <= OUT_MIN[OUT_W-1:0];
		else
			noise_value <= r_w[OUT_W-1:0];
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import sfn_pkg::*;

	localparam int    FRAC     = 16;
	localparam longint ONE_Q   = 64'sd65536;
	localparam longint HALF_SQ = 64'sh8000_0000;
	// skew (sqrt3-1)/2 and unskew (3-sqrt3)/6 at 16 fraction bits
	localparam longint SKEW_K  = 64'sd23988;
	localparam longint UNSKEW_K = 64'sd13849;
	localparam longint NOISE_MAX = 64'sd524287;
	localparam longint NOISE_MIN = -64'sd524288;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam logic [FREQ_W-1:0] FREQ_ONE = 24'd65536;
	localparam logic [FREQ_W-1:0] FREQ_TOP = 24'hFFFFFF;
	localparam int    SETTLE_CYCLES = 16;
	localparam int    CYCLE_LIMIT   = 400000;

	class noise_scoreboard;
		logic signed [OUT_W-1:0] pending_noise[$];
		int errors = 0;

		function longint scale_coord(longint c, longint f);
			longint p;
			p = (c * f) >>> FRAC;
			if (p > COORD_MAX) p = COORD_MAX;
			if (p < COORD_MIN) p = COORD_MIN;
			return p;
		endfunction

		// falloff (0.5 - d^2)^3 of one lattice corner, zero when far
		function longint corner_falloff(longint px, longint pz, longint cx, longint cz);
			longint unsk, dx, dz, t, f, f2;
			unsk = ((cx + cz) * UNSKEW_K) >>> FRAC;
			dx = px - cx * ONE_Q + unsk;
			dz = pz - cz * ONE_Q + unsk;
			if (dx >= ONE_Q || dx <= -ONE_Q || dz >= ONE_Q || dz <= -ONE_Q)
				return 0;
			t = HALF_SQ - dx * dx - dz * dz;
			if (t <= 0)
				return 0;
			f = t >>> FRAC;
			f2 = (f * f) >>> FRAC;
			return (f2 * f) >>> FRAC;
		endfunction

		function logic signed [OUT_W-1:0] predict_noise(logic signed [COORD_W-1:0] x,
				logic signed [COORD_W-1:0] z, logic [FREQ_W-1:0] freq);
			longint px, pz, skew, sx, sz, ix, iz, fx, fz, sum, r;
			px = scale_coord(longint'(x), longint'(freq));
			pz = scale_coord(longint'(z), longint'(freq));
			skew = ((px + pz) * SKEW_K) >>> FRAC;
			sx = px + skew;
			sz = pz + skew;
			ix = sx >>> FRAC;
			iz = sz >>> FRAC;
			fx = sx - ix * ONE_Q;
			fz = sz - iz * ONE_Q;
			sum = corner_falloff(px, pz, ix, iz);
			sum += corner_falloff(px, pz, ix + 1, iz + 1);
			if (fx >= fz)
				sum += corner_falloff(px, pz, ix + 1, iz);
			else
				sum += corner_falloff(px, pz, ix, iz + 1);
			r = sum * 16 - ONE_Q;
			if (r > NOISE_MAX) r = NOISE_MAX;
			if (r < NOISE_MIN) r = NOISE_MIN;
			return r[OUT_W-1:0];
		endfunction

		function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] z,
				logic [FREQ_W-1:0] freq);
			pending_noise.push_back(predict_noise(x, z, freq));
		endfunction

		function void check_noise(logic signed [OUT_W-1:0] got);
			logic signed [OUT_W-1:0] want;
			if (pending_noise.size() == 0) begin
				$error("noise_value: expected none, actual %0d", got);
				errors++;
				return;
			end
			want = pending_noise.pop_front();
			if (got !== want) begin
				$error("noise_value: expected %0d, actual %0d", want, got);
				errors++;
			end
		endfunction

		function int pending();
			return pending_noise.size();
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      start;
	logic                      busy;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_z;
	logic                      cfg_wen;
	logic        [FREQ_W-1:0]  cfg_wdata;
	logic                      done;
	logic signed [OUT_W-1:0]   noise_value;

	logic [FREQ_W-1:0] freq_now;
	int                cycles = 0;
	noise_scoreboard   sb = new();

	simplex_falloff_noise_2d DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.point_x    (point_x),
		.point_z    (point_z),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.done       (done),
		.noise_value(noise_value)
	);

	always #2 clk = ~clk;

	// results first, so a stray word never hides behind a fresh note
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_noise(noise_value);
			if (start && !busy)
				sb.note_point(point_x, point_z, freq_now);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task send_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] z);
		start <= 1'b1;
		point_x <= x;
		point_z <= z;
		do @(posedge clk); while (busy);
	endtask

	task idle_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			point_x <= $urandom;
			point_z <= $urandom;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
	endtask

	task wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task write_frequency(input logic [FREQ_W-1:0] f);
		wait_drained();
		cfg_wen <= 1'b1;
		cfg_wdata <= f;
		@(posedge clk);
		cfg_wen <= 1'b0;
		cfg_wdata <= FREQ_W'($urandom);
		freq_now = f;
	endtask

	task random_point(output logic signed [COORD_W-1:0] x, output logic signed [COORD_W-1:0] z);
		int kind;
		kind = $urandom_range(9);
		if (kind <= 3) begin
			x = $urandom;
			z = $urandom;
		end else if (kind <= 6) begin
			// within a few dozen lattice units of the origin
			x = int'($urandom_range(1 << 22)) - (1 << 21);
			z = int'($urandom_range(1 << 22)) - (1 << 21);
		end else if (kind <= 8) begin
			// close to integer points, where corners fall in and out of range
			x = (int'($urandom_range(200)) - 100) * 65536 + int'($urandom_range(511)) - 256;
			z = (int'($urandom_range(200)) - 100) * 65536 + int'($urandom_range(511)) - 256;
		end else begin
			case ($urandom_range(3))
				0: x = 32'sh7FFF_FFFF;
				1: x = 32'sh8000_0000;
				2: x = 32'sd0;
				default: x = -32'sd1;
			endcase
			z = $urandom_range(1) ? x : $urandom;
		end
	endtask

	task run_phase(input logic [FREQ_W-1:0] f, input int idle_pct, input int n);
		logic signed [COORD_W-1:0] x, z;
		write_frequency(f);
		for (int k = 0; k < n; k++) begin
			random_point(x, z);
			send_point(x, z);
			if (k == n / 2)
				wait_drained();
			else if ((k % 40) >= 8)
				idle_gap(idle_pct);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		point_x = '0;
		point_z = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		freq_now = FREQ_ONE;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset frequency
		send_point(32'sd0, 32'sd0);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(32'sh8000_0000, 32'sh7FFF_FFFF);
		send_point(32'sd1, 32'sd0);
		send_point(32'sd0, 32'sd1);
		send_point(-32'sd1, -32'sd1);
		send_point(32'sd65536, 32'sd0);
		send_point(32'sd0, 32'sd65536);
		// equal fractions, then x ahead, then z ahead
		send_point(32'sd20000, 32'sd20000);
		send_point(32'sd40000, 32'sd12000);
		send_point(32'sd12000, 32'sd40000);
		send_point(-32'sd65536, 32'sd32768);
		send_point(32'sd74000, 32'sd73000);
		send_point(32'sh0001_2000, 32'sh0000_A000);

		// top frequency, where large scaled coordinates saturate
		write_frequency(FREQ_TOP);
		send_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(32'sh8000_0000, 32'sh8000_0000);
		send_point(32'sd65536, -32'sd65536);
		send_point(32'sh0100_0000, 32'sh0000_0100);
		send_point(32'sd1, -32'sd1);

		write_frequency('0);
		send_point(32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(32'sd123456, -32'sd654321);

		run_phase(FREQ_ONE, 0, 100);
		run_phase('0, 87, 30);
		run_phase(FREQ_TOP, 12, 60);
		run_phase(24'($urandom_range(1 << 20, 1 << 10)), 87, 120);
		run_phase(24'd1, 0, 30);
		run_phase(24'($urandom), 12, 100);
		run_phase(FREQ_ONE, 87, 60);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("noise_value: %0d results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
